[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the PID turn controller: field widths,
// configuration register indexes, gain set and pipeline stage structures.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Field widths
    localparam int DEV_W   = 8;
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 32;
    localparam int DIFF_W  = DEV_W + 1;
    localparam int TURN_W  = 8;
    localparam int CIDX_W  = 3;

    // Output clamp magnitude
    localparam int TURN_LIMIT = 100;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_ALT_GAIN_P = 3'd3,
        CFG_ALT_GAIN_I = 3'd4,
        CFG_ALT_GAIN_D = 3'd5,
        CFG_EDGE_RIGHT = 3'd6
    } cfg_index_t;

    // One set of Q7.8 gains
    typedef struct packed {
        logic signed [GAIN_W-1:0] p;
        logic signed [GAIN_W-1:0] i;
        logic signed [GAIN_W-1:0] d;
    } gain_set_t;

    // Full configuration as seen by the datapath
    typedef struct packed {
        gain_set_t norm;
        gain_set_t alt;
        logic      edge_right;
    } cfg_t;

    // Front stage result: the three PID components and the gain set pick
    typedef struct packed {
        logic signed [DEV_W-1:0]   p;
        logic signed [INTEG_W-1:0] i;
        logic signed [DIFF_W-1:0]  d;
        logic                      alt;
    } stage_t;

endpackage

[rtl/ptc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ptc_cfg_regs
// Configuration register file: two gain sets and the edge direction bit.
// Writes to indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module ptc_cfg_regs import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take configuration writes
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:     cfg_next.norm.p     = cfg_data;
                CFG_GAIN_I:     cfg_next.norm.i     = cfg_data;
                CFG_GAIN_D:     cfg_next.norm.d     = cfg_data;
                CFG_ALT_GAIN_P: cfg_next.alt.p      = cfg_data;
                CFG_ALT_GAIN_I: cfg_next.alt.i      = cfg_data;
                CFG_ALT_GAIN_D: cfg_next.alt.d      = cfg_data;
                CFG_EDGE_RIGHT: cfg_next.edge_right = cfg_data[0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.norm.p     <= GAIN_W'(512);
            cfg_reg.norm.i     <= '0;
            cfg_reg.norm.d     <= GAIN_W'(1280);
            cfg_reg.alt.p      <= '0;
            cfg_reg.alt.i      <= '0;
            cfg_reg.alt.d      <= '0;
            cfg_reg.edge_right <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/ptc_front.sv]
// ----------------------------------------------------------------------------
// ptc_front
// Input stage: accepts a deviation, updates the saturating integral and the
// deviation history, and registers the P, I and D components.
// ----------------------------------------------------------------------------
module ptc_front import ptc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [DEV_W-1:0] s_deviation,
    input  logic                    s_use_alt_gains,
    output logic                    stg_valid,
    input  logic                    stg_ready,
    output stage_t                  stg
);

    logic                      stg_valid_reg;
    logic                      stg_valid_next;
    stage_t                    stg_reg;
    stage_t                    stg_next;
    logic signed [DEV_W-1:0]   last_dev_reg;
    logic signed [INTEG_W-1:0] error_sum_reg;
    logic signed [INTEG_W:0]   integ_wide;
    logic signed [INTEG_W-1:0] integ_sat;
    logic                      accept;

    assign s_ready   = !stg_valid_reg || stg_ready;
    assign accept    = s_valid && s_ready;
    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

    // Add the deviation into the integral, saturate on overflow
    always_comb begin
        integ_wide = {error_sum_reg[INTEG_W-1], error_sum_reg}
                   + {{(INTEG_W + 1 - DEV_W){s_deviation[DEV_W-1]}}, s_deviation};
        if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
            integ_sat = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_wide[INTEG_W-1:0];
        end
    end

    // Form the stage contents
    always_comb begin
        stg_next.p   = s_deviation;
        stg_next.i   = integ_sat;
        stg_next.d   = {s_deviation[DEV_W-1], s_deviation}
                     - {last_dev_reg[DEV_W-1], last_dev_reg};
        stg_next.alt = s_use_alt_gains;
        stg_valid_next = s_ready ? s_valid : stg_valid_reg;
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            last_dev_reg  <= '0;
            error_sum_reg <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            if (accept) begin
                last_dev_reg  <= s_deviation;
                error_sum_reg <= integ_sat;
            end
        end
    end

    // Payload register
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_reg <= stg_next;
        end
    end

    // History follows the accepted deviation
    a_history: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && aresetn) |=> (last_dev_reg == $past(s_deviation)))
        else $error("deviation history not updated on accept");

    // Stalled stage holds its contents
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && stg_valid_reg && !stg_ready) |=> (stg_valid_reg && $stable(stg_reg)))
        else $error("front stage changed while stalled");

endmodule

[rtl/ptc_back.sv]
// ----------------------------------------------------------------------------
// ptc_back
// Product and output stages: multiplies each component by its gain, then
// truncates toward zero, sums, applies the edge sign and clamps the result.
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     stg_valid,
    output logic                     stg_ready,
    input  stage_t                   stg,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TURN_W-1:0] m_turn
);

    localparam int PP_W  = GAIN_W + DEV_W;
    localparam int PI_W  = GAIN_W + INTEG_W;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int SUM_W = PI_W - 8 + 2;
    localparam logic signed [SUM_W-1:0] LIM = SUM_W'(TURN_LIMIT);

    // Divide a product by 256, rounding toward zero
    function automatic logic signed [PI_W-9:0] div256_tz(input logic signed [PI_W-1:0] v);
        logic signed [PI_W-1:0] biased;
        biased = v + (v[PI_W-1] ? PI_W'(255) : PI_W'(0));
        return biased[PI_W-1:8];
    endfunction

    gain_set_t                gains;
    logic                     prod_valid_reg;
    logic                     prod_valid_next;
    logic signed [PP_W-1:0]   prod_p_reg;
    logic signed [PI_W-1:0]   prod_i_reg;
    logic signed [PD_W-1:0]   prod_d_reg;
    logic signed [PP_W-1:0]   prod_p_next;
    logic signed [PI_W-1:0]   prod_i_next;
    logic signed [PD_W-1:0]   prod_d_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [TURN_W-1:0] turn_reg;
    logic signed [TURN_W-1:0] turn_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  signed_sum;
    logic                     out_adv;
    logic                     prod_load;

    assign out_adv   = !out_valid_reg || m_ready;
    assign stg_ready = !prod_valid_reg || out_adv;
    assign prod_load = stg_valid && stg_ready;
    assign m_valid   = out_valid_reg;
    assign m_turn    = turn_reg;

    // Pick the gain set and multiply
    always_comb begin
        gains       = stg.alt ? cfg.alt : cfg.norm;
        prod_p_next = gains.p * stg.p;
        prod_i_next = gains.i * stg.i;
        prod_d_next = gains.d * stg.d;
        prod_valid_next = stg_ready ? stg_valid : prod_valid_reg;
    end

    // Truncate the terms, sum, apply direction and clamp
    always_comb begin
        sum = SUM_W'(div256_tz(PI_W'(prod_p_reg)))
            + SUM_W'(div256_tz(prod_i_reg))
            + SUM_W'(div256_tz(PI_W'(prod_d_reg)));
        signed_sum = cfg.edge_right ? sum : -sum;
        if (signed_sum >= LIM) begin
            turn_next = TURN_W'(LIM);
        end else if (signed_sum <= -LIM) begin
            turn_next = TURN_W'(-LIM);
        end else begin
            turn_next = signed_sum[TURN_W-1:0];
        end
        out_valid_next = out_adv ? prod_valid_reg : out_valid_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (prod_valid_reg && out_adv) begin
            turn_reg <= turn_next;
        end
    end

    // Result stays inside the clamp range
    a_turn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_turn <= TURN_W'(TURN_LIMIT)) && (m_turn >= -TURN_W'(TURN_LIMIT))))
        else $error("turn outside clamp range");

    // An empty output register fills from a full product stage
    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && prod_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("product stage did not advance into empty output");

    // Product stage never overflows
    a_prod_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && prod_valid_reg && !out_adv) |=> prod_valid_reg)
        else $error("stalled product stage lost its transaction");

endmodule

[rtl/pid_turn_controller_top.sv]
// ----------------------------------------------------------------------------
// pid_turn_controller_top
// Line-following steering PID with two gain sets, shared integral and
// deviation history, and a clamped turn command.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+-----------
//   input    | s_valid s_ready s_deviation        | in
//            | s_use_alt_gains                    |
//   result   | m_valid m_ready m_turn             | out
//   config   | cfg_valid cfg_ready cfg_index      | in
//            | cfg_data                           |
//
// One transaction per cycle sustained while m_ready is high; an accepted input
// is registered in the front stage, product stage and output register in turn.
// The product stage sets the cycle: a 16x32 multiply for the integral term.
// Reset is synchronous; integral, history and configuration return to defaults.
// A stalled result backs up through the stages; input is taken while any
// stage still has room.
// ----------------------------------------------------------------------------
module pid_turn_controller_top import ptc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DEV_W-1:0]  s_deviation,
    input  logic                     s_use_alt_gains,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TURN_W-1:0] m_turn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data
);

    cfg_t   cfg;
    stage_t stg;
    logic   stg_valid;
    logic   stg_ready;

    // Configuration registers
    ptc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Integral, history and component stage
    ptc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_deviation     (s_deviation),
        .s_use_alt_gains (s_use_alt_gains),
        .stg_valid       (stg_valid),
        .stg_ready       (stg_ready),
        .stg             (stg)
    );

    // Products, sum and clamp
    ptc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .stg_valid (stg_valid),
        .stg_ready (stg_ready),
        .stg       (stg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_turn    (m_turn)
    );

endmodule
